### hdl/shgd_pkg.sv
// ----------------------------------------------------------------------------
// shgd_pkg
// Shared types, register indexes, defaults and helpers of the skeleton
// hand gesture detector.
// ----------------------------------------------------------------------------
package shgd_pkg;

    localparam int USER_W      = 3;
    localparam int COORD_W     = 16;
    localparam int MODE_W      = 3;
    localparam int CNT_W       = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int MAX_USERS_DEF = 8;

    localparam logic [CNT_W-1:0]   ARM_FRAMES_RST   = 8'd10;
    localparam logic [CNT_W-1:0]   WAVE_LIMIT_RST   = 8'd4;
    localparam logic [CNT_W-1:0]   STILL_LIMIT_RST  = 8'd4;
    localparam logic [COORD_W-1:0] NEAR_DEPTH_RST   = 16'd200;
    localparam logic [COORD_W-1:0] FAST_MIN_RST     = 16'd8;
    localparam logic [COORD_W-1:0] SLOW_MAX_RST     = 16'd2;
    localparam logic [MODE_W-1:0]  RAISED_MODE_RST  = 3'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ARM_FRAMES  = 3'd0,
        REG_WAVE_LIMIT  = 3'd1,
        REG_STILL_LIMIT = 3'd2,
        REG_NEAR_DEPTH  = 3'd3,
        REG_FAST_MIN    = 3'd4,
        REG_SLOW_MAX    = 3'd5,
        REG_RAISED_MODE = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_START = 2'd2
    } hand_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0]   arm_frames;
        logic [CNT_W-1:0]   wave_count_limit;
        logic [CNT_W-1:0]   still_count_limit;
        logic [COORD_W-1:0] near_depth_limit;
        logic [COORD_W-1:0] fast_move_min;
        logic [COORD_W-1:0] slow_move_max;
        logic [MODE_W-1:0]  raised_mode_code;
    } cfg_t;

    typedef struct packed {
        logic                      frame_start;
        logic [USER_W-1:0]         user_index;
        logic signed [COORD_W-1:0] right_hand_x;
        logic signed [COORD_W-1:0] right_hand_y;
        logic [MODE_W-1:0]         right_hand_mode;
        logic signed [COORD_W-1:0] left_hand_y;
        logic [MODE_W-1:0]         left_hand_mode;
        logic signed [COORD_W-1:0] torso_y;
        logic signed [COORD_W-1:0] head_x;
        logic signed [COORD_W-1:0] head_y;
        logic signed [COORD_W-1:0] head_z;
    } item_t;

    typedef struct packed {
        logic [USER_W-1:0] for_user;
        hand_cmd_t         hand_command;
        logic              wave_seen;
    } result_t;

    function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

endpackage

### hdl/shgd_item_if.sv
// ----------------------------------------------------------------------------
// shgd_item_if / shgd_result_if
// Valid/ready channels for joint records and gesture results.
// ----------------------------------------------------------------------------
interface shgd_item_if
    import shgd_pkg::*;
();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface shgd_result_if
    import shgd_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/shgd_cfg_regs.sv
// ----------------------------------------------------------------------------
// shgd_cfg_regs
// Configuration register bank, write only, unknown indexes ignored.
// ----------------------------------------------------------------------------
module shgd_cfg_regs
    import shgd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_ARM_FRAMES:  cfg_next.arm_frames        = cfg_data[CNT_W-1:0];
                REG_WAVE_LIMIT:  cfg_next.wave_count_limit  = cfg_data[CNT_W-1:0];
                REG_STILL_LIMIT: cfg_next.still_count_limit = cfg_data[CNT_W-1:0];
                REG_NEAR_DEPTH:  cfg_next.near_depth_limit  = cfg_data[COORD_W-1:0];
                REG_FAST_MIN:    cfg_next.fast_move_min     = cfg_data[COORD_W-1:0];
                REG_SLOW_MAX:    cfg_next.slow_move_max     = cfg_data[COORD_W-1:0];
                REG_RAISED_MODE: cfg_next.raised_mode_code  = cfg_data[MODE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.arm_frames        <= ARM_FRAMES_RST;
            cfg_reg.wave_count_limit  <= WAVE_LIMIT_RST;
            cfg_reg.still_count_limit <= STILL_LIMIT_RST;
            cfg_reg.near_depth_limit  <= NEAR_DEPTH_RST;
            cfg_reg.fast_move_min     <= FAST_MIN_RST;
            cfg_reg.slow_move_max     <= SLOW_MAX_RST;
            cfg_reg.raised_mode_code  <= RAISED_MODE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/shgd_judge.sv
// ----------------------------------------------------------------------------
// shgd_judge
// Per-record gesture judgement: frame arming, hand commands, per-user
// move counters and wave detection. State advances on each fire.
// ----------------------------------------------------------------------------
module shgd_judge
    import shgd_pkg::*;
#(
    parameter int MAX_USERS = MAX_USERS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    localparam int USER_IDX_W = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;

    logic [CNT_W-1:0]   wait_frames_reg;
    logic [CNT_W-1:0]   wait_frames_next;
    logic               frame_armed_reg;
    logic               frame_armed_next;
    logic [COORD_W-1:0] prev_x_reg;
    logic [COORD_W-1:0] prev_x_next;
    logic [CNT_W-1:0]   fast_reg [MAX_USERS];
    logic [CNT_W-1:0]   slow_reg [MAX_USERS];
    logic [CNT_W-1:0]   fast_new;
    logic [CNT_W-1:0]   slow_new;

    logic                  user_valid;
    logic [USER_IDX_W-1:0] idx;
    logic                  near;
    logic                  right_raised;
    logic                  left_raised;
    logic                  in_pose;
    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]      abs_diff;
    logic                  wave;
    hand_cmd_t             cmd;

    assign user_valid   = (int'(item.user_index) < MAX_USERS);
    assign idx          = USER_IDX_W'(item.user_index);
    assign near         = $signed({item.head_z[COORD_W-1], item.head_z})
                          < $signed({1'b0, cfg.near_depth_limit});
    assign right_raised = (item.right_hand_mode == cfg.raised_mode_code);
    assign left_raised  = (item.left_hand_mode == cfg.raised_mode_code);
    assign in_pose      = (item.head_x < item.right_hand_x)
                          && (item.torso_y < item.right_hand_y) && right_raised;
    assign diff         = $signed({prev_x_reg[COORD_W-1], prev_x_reg})
                          - $signed({item.right_hand_x[COORD_W-1], item.right_hand_x});
    assign abs_diff     = diff[COORD_W] ? unsigned'(-diff) : unsigned'(diff);

    always_comb
    begin
        wait_frames_next = wait_frames_reg;
        frame_armed_next = frame_armed_reg;
        prev_x_next      = prev_x_reg;
        fast_new         = '0;
        slow_new         = '0;
        wave             = 1'b0;
        cmd              = CMD_NONE;

        if (item.frame_start)
        begin
            frame_armed_next = (wait_frames_reg > cfg.arm_frames);
            if (!frame_armed_next)
            begin
                wait_frames_next = inc_sat(wait_frames_reg);
            end
        end

        if (frame_armed_next)
        begin
            if (user_valid)
            begin
                fast_new = fast_reg[idx];
                slow_new = slow_reg[idx];
            end
            if (user_valid && (fast_new > cfg.wave_count_limit))
            begin
                wave             = 1'b1;
                wait_frames_next = '0;
                fast_new         = '0;
                slow_new         = '0;
            end
            if (slow_new > cfg.still_count_limit)
            begin
                fast_new = '0;
                slow_new = '0;
            end
            priority if (item.head_y < item.right_hand_y && right_raised && near)
            begin
                cmd = CMD_STOP;
            end
            else if (item.head_y < item.left_hand_y && left_raised && near)
            begin
                cmd = CMD_START;
            end
            else
            begin
                cmd = CMD_NONE;
            end
            if (user_valid && in_pose)
            begin
                prev_x_next = item.right_hand_x;
                if (abs_diff >= {1'b0, cfg.fast_move_min})
                begin
                    fast_new = inc_sat(fast_new);
                end
                if (abs_diff <= {1'b0, cfg.slow_move_max})
                begin
                    slow_new = inc_sat(slow_new);
                end
            end
            else
            begin
                fast_new = '0;
                slow_new = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_frames_reg <= '0;
            frame_armed_reg <= 1'b0;
            prev_x_reg      <= '0;
            for (int k = 0; k < MAX_USERS; k++)
            begin
                fast_reg[k] <= '0;
                slow_reg[k] <= '0;
            end
        end
        else if (fire)
        begin
            wait_frames_reg <= wait_frames_next;
            frame_armed_reg <= frame_armed_next;
            prev_x_reg      <= prev_x_next;
            if (user_valid)
            begin
                fast_reg[idx] <= fast_new;
                slow_reg[idx] <= slow_new;
            end
        end
    end

    assign res.for_user     = item.user_index;
    assign res.hand_command = cmd;
    assign res.wave_seen    = wave;

    // a wave restarts the arming count
    a_wave_clears_wait: assert property (@(posedge clk) disable iff (!rst_n)
        fire && wave |=> wait_frames_reg == '0)
        else $error("wait count not cleared after wave");

    // nothing is judged in an unarmed frame
    a_unarmed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !frame_armed_next |-> cmd == CMD_NONE && !wave)
        else $error("result reported in unarmed frame");

    // out-of-range users never wave and leave the shared x alone
    a_bad_user: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !user_valid |=> !$past(wave) && prev_x_reg == $past(prev_x_reg))
        else $error("out-of-range user changed state");

endmodule

### hdl/skeleton_hand_gesture_detector.sv
// ----------------------------------------------------------------------------
// skeleton_hand_gesture_detector
// Path: a record taken passes the input register, then the result register;
//   a result that is not taken holds the record in the input register.
// Throughput: one record per cycle while results are taken; one judge pass.
// Reset: counters, arming state and shared x clear at once; registers load
//   their defaults.
// ----------------------------------------------------------------------------
module skeleton_hand_gesture_detector
    import shgd_pkg::*;
#(
    parameter int MAX_USERS = MAX_USERS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    shgd_item_if.sink             item,
    shgd_result_if.source         result,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    logic    item_valid_next;
    result_t result_reg;
    result_t judged;
    logic    result_valid_reg;
    logic    result_valid_next;
    logic    advance;
    logic    take;

    shgd_cfg_regs u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    shgd_judge #(
        .MAX_USERS (MAX_USERS)
    ) u_judge (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (judged)
    );

    assign advance    = item_valid_reg && (!result_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        item_valid_next = take ? 1'b1 : (advance ? 1'b0 : item_valid_reg);
        result_valid_next = advance ? 1'b1
                          : (result.ready ? 1'b0 : result_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item.data;
        end
        if (advance)
        begin
            result_reg <= judged;
        end
    end

    assign result.valid = result_valid_reg;
    assign result.data  = result_reg;

    // an empty input stage always takes a record
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid_reg |-> item.ready)
        else $error("input stage empty but not ready");

endmodule
